[sv/adcma_pkg.sv]
// ----------------------------------------------------------------------------
// adcma_pkg
// Shared types and constants for the two-channel moving average block.
// ----------------------------------------------------------------------------
`default_nettype none

package adcma_pkg;

  // converter mux select width
  localparam int MUX_BITS = 4;

  // configuration port
  localparam int CFG_INDEX_BITS = 1;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_FIRST_CHANNEL  = 1'b0,
    CFG_SECOND_CHANNEL = 1'b1
  } cfg_index_t;

  // reset values of the channel registers
  localparam logic [MUX_BITS-1:0] FIRST_CHANNEL_RESET  = 4'd0;
  localparam logic [MUX_BITS-1:0] SECOND_CHANNEL_RESET = 4'd1;

  // per-cycle commands broadcast to the ring cells
  typedef struct packed {
    logic metal_wr;
    logic color_wr;
    logic advance;
  } cell_ctrl_t;

endpackage

`default_nettype wire

[sv/adc_dual_channel_moving_average.sv]
// ----------------------------------------------------------------------------
// adc_dual_channel_moving_average
// Two-channel boxcar average of converter samples with mux and settle control.
// ----------------------------------------------------------------------------
// Takes one input word per clock cycle unless stalled and gives exactly one
// result word for each through the output register. A skid stage holds one
// more word while the output is stalled; the input is then stalled until the
// cycle after that word moves into the output register. Each done tick with
// no settle hold starts the hold and, with sampling enabled, stores the
// sample into the selected channel's ring, updates that channel's running sum
// with one subtract and one add and flips the channel. One word per unstalled
// cycle rests on the combinational sum update and the ring cells, which each
// hold one metal and one color entry and pass the index token along. Channel
// numbers are to be written on the cfg port (index 0 metal/first, index 1
// color/second) only while the block is idle; the block does not enforce it.
// Sums cover the last WINDOW_LENGTH samples of each of two distinct channels.
// ----------------------------------------------------------------------------
`default_nettype none

module adc_dual_channel_moving_average #(
  parameter int WINDOW_LENGTH = 10,
  parameter int HOLD_TICKS    = 3,
  parameter int SAMPLE_BITS   = 10,
  localparam int SUM_BITS     = $clog2(WINDOW_LENGTH * ((1 << SAMPLE_BITS) - 1) + 1)
) (
  input  wire                                   clk,
  input  wire                                   rst,
  // configuration
  input  wire                                   cfg_write,
  input  wire  [adcma_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire  [adcma_pkg::MUX_BITS-1:0]        cfg_data,
  // input words
  input  wire                                   in_valid,
  output logic                                  in_stall,
  input  wire                                   conversion_done,
  input  wire  [SAMPLE_BITS-1:0]                sample_value,
  input  wire                                   sampling_enabled,
  // result words
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output logic                                  start_conversion,
  output logic [adcma_pkg::MUX_BITS-1:0]        mux_select,
  output logic [SUM_BITS-1:0]                   metal_sum,
  output logic [SUM_BITS-1:0]                   color_sum
);

  localparam int HOLD_BITS = $clog2(HOLD_TICKS + 2);
  localparam logic [HOLD_BITS-1:0] HOLD_LIMIT = HOLD_BITS'(HOLD_TICKS);
  localparam logic [HOLD_BITS-1:0] HOLD_FIRST = HOLD_BITS'(1);
  localparam int OUT_BITS = 1 + adcma_pkg::MUX_BITS + 2 * SUM_BITS;

  logic [adcma_pkg::MUX_BITS-1:0] first_channel;
  logic [adcma_pkg::MUX_BITS-1:0] second_channel;
  logic [HOLD_BITS-1:0]           hold_count;
  logic [HOLD_BITS-1:0]           hold_count_next;
  logic                           on_second_channel;
  logic                           on_second_channel_next;
  logic [SUM_BITS-1:0]            metal_total;
  logic [SUM_BITS-1:0]            metal_total_next;
  logic [SUM_BITS-1:0]            color_total;
  logic [SUM_BITS-1:0]            color_total_next;

  logic                           accept;
  logic                           start_next;
  logic                           store;
  logic                           to_metal;
  logic [adcma_pkg::MUX_BITS-1:0] sel_channel;
  logic [adcma_pkg::MUX_BITS-1:0] mux_next;
  adcma_pkg::cell_ctrl_t          ctrl;

  logic [WINDOW_LENGTH-1:0]       token;
  logic [SAMPLE_BITS-1:0]         metal_tap [WINDOW_LENGTH];
  logic [SAMPLE_BITS-1:0]         color_tap [WINDOW_LENGTH];
  logic [SAMPLE_BITS-1:0]         metal_old;
  logic [SAMPLE_BITS-1:0]         color_old;

  logic [OUT_BITS-1:0]            result_word;
  logic [OUT_BITS-1:0]            out_word;

  // channel registers
  always_ff @(posedge clk) begin
    if (rst) begin
      first_channel  <= adcma_pkg::FIRST_CHANNEL_RESET;
      second_channel <= adcma_pkg::SECOND_CHANNEL_RESET;
    end else if (cfg_write) begin
      case (adcma_pkg::cfg_index_t'(cfg_index))
        adcma_pkg::CFG_FIRST_CHANNEL:  first_channel  <= cfg_data;
        adcma_pkg::CFG_SECOND_CHANNEL: second_channel <= cfg_data;
        default: ;
      endcase
    end
  end

  // tick decode
  assign accept      = in_valid && !in_stall;
  assign sel_channel = on_second_channel ? second_channel : first_channel;
  assign to_metal    = (sel_channel == first_channel);
  assign store       = conversion_done && (hold_count == '0) && sampling_enabled;

  assign ctrl.metal_wr = accept && store && to_metal;
  assign ctrl.color_wr = accept && store && !to_metal;
  assign ctrl.advance  = ctrl.color_wr;

  // settle hold counter and start pulse
  always_comb begin
    hold_count_next = hold_count;
    start_next      = 1'b0;
    if (conversion_done) begin
      if (hold_count != '0) begin
        if (hold_count > HOLD_LIMIT) begin
          start_next      = 1'b1;
          hold_count_next = '0;
        end else begin
          hold_count_next = hold_count + HOLD_FIRST;
        end
      end else begin
        hold_count_next = HOLD_FIRST;
      end
    end
  end

  // channel toggle
  assign on_second_channel_next = store ? to_metal : on_second_channel;
  assign mux_next = on_second_channel_next ? second_channel : first_channel;

  // oldest entries from the token cell
  always_comb begin
    metal_old = '0;
    color_old = '0;
    for (int i = 0; i < WINDOW_LENGTH; i++) begin
      metal_old = metal_old | metal_tap[i];
      color_old = color_old | color_tap[i];
    end
  end

  // running sums
  always_comb begin
    metal_total_next = metal_total;
    color_total_next = color_total;
    if (ctrl.metal_wr) begin
      metal_total_next = metal_total - SUM_BITS'(metal_old) + SUM_BITS'(sample_value);
    end
    if (ctrl.color_wr) begin
      color_total_next = color_total - SUM_BITS'(color_old) + SUM_BITS'(sample_value);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_count        <= '0;
      on_second_channel <= 1'b0;
      metal_total       <= '0;
      color_total       <= '0;
    end else if (accept) begin
      hold_count        <= hold_count_next;
      on_second_channel <= on_second_channel_next;
      metal_total       <= metal_total_next;
      color_total       <= color_total_next;
    end
  end

  // ring of cells, token passes from cell i-1 to cell i
  for (genvar i = 0; i < WINDOW_LENGTH; i++) begin : g_cell
    localparam int PREV = (i + WINDOW_LENGTH - 1) % WINDOW_LENGTH;
    adcma_cell #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .FIRST_CELL  (i == 0)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .sample    (sample_value),
      .token_in  (token[PREV]),
      .token_out (token[i]),
      .metal_tap (metal_tap[i]),
      .color_tap (color_tap[i])
    );
  end

  // result word into the output register
  assign result_word = {start_next, mux_next, metal_total_next, color_total_next};

  adcma_skid #(
    .WIDTH (OUT_BITS)
  ) u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (result_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_word)
  );

  assign {start_conversion, mux_select, metal_sum, color_sum} = out_word;

`ifndef SYNTHESIS
  // exactly one cell holds the ring index
  assert property (@(posedge clk) disable iff (rst) $onehot(token))
    else $error("ring index token not one-hot");

  // one sample never goes to both rings
  assert property (@(posedge clk) disable iff (rst) !(ctrl.metal_wr && ctrl.color_wr))
    else $error("sample written to both rings");

  // hold counter never exceeds HOLD_LIMIT plus one
  assert property (@(posedge clk) disable iff (rst) hold_count <= HOLD_LIMIT + HOLD_FIRST)
    else $error("settle hold counter out of range");

  // a tick without a finished conversion leaves the sums alone
  assert property (@(posedge clk) disable iff (rst)
    (accept && !conversion_done) |=> ($stable(metal_total) && $stable(color_total)))
    else $error("running sum changed without a conversion");

  // the token moves only after a color sample
  assert property (@(posedge clk) disable iff (rst)
    !ctrl.advance |=> $stable(token))
    else $error("ring index moved without a color sample");
`endif

endmodule

`default_nettype wire

[sv/adcma_cell.sv]
// ----------------------------------------------------------------------------
// adcma_cell
// One ring position: holds one metal and one color sample plus the index
// token, which moves on to the next cell when the shared index advances.
// ----------------------------------------------------------------------------
`default_nettype none

module adcma_cell #(
  parameter int SAMPLE_BITS = 10,
  parameter bit FIRST_CELL  = 1'b0
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire adcma_pkg::cell_ctrl_t ctrl,
  input  wire  [SAMPLE_BITS-1:0]     sample,
  input  wire                        token_in,
  output logic                       token_out,
  output logic [SAMPLE_BITS-1:0]     metal_tap,
  output logic [SAMPLE_BITS-1:0]     color_tap
);

  logic                   token;
  logic [SAMPLE_BITS-1:0] metal;
  logic [SAMPLE_BITS-1:0] color;

  // index token, handed to the neighbor on advance
  always_ff @(posedge clk) begin
    if (rst) begin
      token <= FIRST_CELL;
    end else if (ctrl.advance) begin
      token <= token_in;
    end
  end

  // sample storage, written only where the token sits
  always_ff @(posedge clk) begin
    if (rst) begin
      metal <= '0;
      color <= '0;
    end else begin
      if (ctrl.metal_wr && token) begin
        metal <= sample;
      end
      if (ctrl.color_wr && token) begin
        color <= sample;
      end
    end
  end

  // oldest entry shows only from the token cell
  assign token_out = token;
  assign metal_tap = token ? metal : '0;
  assign color_tap = token ? color : '0;

endmodule

`default_nettype wire

[sv/adcma_skid.sv]
// ----------------------------------------------------------------------------
// adcma_skid
// Output register with a skid stage so a new word can enter while a
// finished word still waits downstream.
// ----------------------------------------------------------------------------
`default_nettype none

module adcma_skid #(
  parameter int WIDTH = 33
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  output logic             in_stall,
  input  wire  [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  wire              out_stall,
  output logic [WIDTH-1:0] out_data
);

  logic             main_valid;
  logic [WIDTH-1:0] main_data;
  logic             skid_valid;
  logic [WIDTH-1:0] skid_data;
  logic             take;
  logic             fire;

  assign in_stall  = skid_valid;
  assign take      = in_valid && !skid_valid;
  assign fire      = main_valid && !out_stall;
  assign out_valid = main_valid;
  assign out_data  = main_data;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (fire) begin
        skid_valid <= 1'b0;
      end
    end else if (!main_valid || fire) begin
      main_valid <= take;
    end else if (take) begin
      skid_valid <= 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (fire) begin
        main_data <= skid_data;
      end
    end else if (!main_valid || fire) begin
      main_data <= in_data;
    end else begin
      skid_data <= in_data;
    end
  end

endmodule

`default_nettype wire

[tb/tb_adc_dual_channel_moving_average.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_adc_dual_channel_moving_average
// Self-checking bench for the two-channel boxcar average block.
// ----------------------------------------------------------------------------
// Queued tick words are pushed through the input handshake by a clocked
// driver. Every accepted tick is run through a cycle-free copy of the
// averaging and settle-hold logic, and the predicted result word is queued.
// A clocked monitor stalls the result side at random and compares each
// result word field by field with the oldest prediction. Six phases step
// through channel register settings (extremes and equal channels included)
// and three idling patterns; the first phase opens with directed ticks.
// ----------------------------------------------------------------------------

module tb_adc_dual_channel_moving_average;

  localparam int SAMPLE_W        = 10;
  localparam int SUM_W           = 14;
  localparam int WIN             = 10;
  localparam int HOLD_LIMIT      = 3;
  localparam int PHASES          = 6;
  localparam int TICKS_PER_PHASE = 175;
  localparam int QUIET_LIMIT     = 4000;
  localparam int DRAIN_CYCLES    = 8;

  typedef struct packed {
    logic                done;
    logic [SAMPLE_W-1:0] sample;
    logic                enabled;
  } tick_t;

  typedef struct packed {
    logic                           start;
    logic [adcma_pkg::MUX_BITS-1:0] mux;
    logic [SUM_W-1:0]               metal;
    logic [SUM_W-1:0]               color;
  } avg_word_t;

  // clock, reset and block ports
  logic                           clk              = 1'b0;
  logic                           rst              = 1'b1;
  logic                           cfg_write        = 1'b0;
  adcma_pkg::cfg_index_t          cfg_index        = adcma_pkg::CFG_FIRST_CHANNEL;
  logic [adcma_pkg::MUX_BITS-1:0] cfg_data         = '0;
  logic                           in_valid         = 1'b0;
  logic                           in_stall;
  logic                           conversion_done  = 1'b0;
  logic [SAMPLE_W-1:0]            sample_value     = '0;
  logic                           sampling_enabled = 1'b0;
  logic                           out_valid;
  logic                           out_stall        = 1'b0;
  logic                           start_conversion;
  logic [adcma_pkg::MUX_BITS-1:0] mux_select;
  logic [SUM_W-1:0]               metal_sum;
  logic [SUM_W-1:0]               color_sum;

  adc_dual_channel_moving_average dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .conversion_done  (conversion_done),
    .sample_value     (sample_value),
    .sampling_enabled (sampling_enabled),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .start_conversion (start_conversion),
    .mux_select       (mux_select),
    .metal_sum        (metal_sum),
    .color_sum        (color_sum)
  );

  always #4 clk = ~clk;

  // pending ticks, predicted result words, bookkeeping
  tick_t     tick_q[$];
  avg_word_t avg_q[$];
  tick_t     driven_tick;
  avg_word_t predicted_word;
  avg_word_t wanted_word;
  int        mismatch_count = 0;
  int        quiet_cycles   = 0;
  int        send_idle_pct  = 0;
  int        recv_idle_pct  = 0;

  // shadow of the block state and channel registers
  logic [adcma_pkg::MUX_BITS-1:0] first_ch  = adcma_pkg::FIRST_CHANNEL_RESET;
  logic [adcma_pkg::MUX_BITS-1:0] second_ch = adcma_pkg::SECOND_CHANNEL_RESET;
  logic [2:0]                     hold_cnt  = '0;
  logic                           on_second = 1'b0;
  logic [SAMPLE_W-1:0]            metal_win [WIN];
  logic [SAMPLE_W-1:0]            color_win [WIN];
  logic [SUM_W-1:0]               metal_acc = '0;
  logic [SUM_W-1:0]               color_acc = '0;
  logic [3:0]                     slot      = '0;

  // one tick of the averaging and settle logic
  function automatic avg_word_t advance_average(input tick_t t);
    avg_word_t w;
    logic      pulse;
    pulse = 1'b0;
    if (t.done) begin
      if (hold_cnt != 0) begin
        if (hold_cnt > HOLD_LIMIT) begin
          pulse    = 1'b1;
          hold_cnt = '0;
        end else begin
          hold_cnt = hold_cnt + 1'b1;
        end
      end else begin
        if (t.enabled) begin
          // equal registers keep every sample on the metal side
          if ((on_second ? second_ch : first_ch) == first_ch) begin
            on_second       = 1'b1;
            metal_acc       = metal_acc - metal_win[slot] + t.sample;
            metal_win[slot] = t.sample;
          end else begin
            on_second       = 1'b0;
            color_acc       = color_acc - color_win[slot] + t.sample;
            color_win[slot] = t.sample;
            slot            = (slot == WIN - 1) ? 4'd0 : slot + 4'd1;
          end
        end
        hold_cnt = 3'd1;
      end
    end
    w.start = pulse;
    w.mux   = on_second ? second_ch : first_ch;
    w.metal = metal_acc;
    w.color = color_acc;
    return w;
  endfunction

  function automatic tick_t random_tick();
    tick_t t;
    t.done    = ($urandom_range(99) < 85);
    t.enabled = ($urandom_range(99) < 85);
    case ($urandom_range(9))
      0:       t.sample = '0;
      1:       t.sample = '1;
      default: t.sample = SAMPLE_W'($urandom_range(1023));
    endcase
    return t;
  endfunction

  task automatic push_tick(input logic d, input logic [SAMPLE_W-1:0] s, input logic e);
    tick_q.push_back(tick_t'{done: d, sample: s, enabled: e});
  endtask

  // four done ticks run the settle hold out to its start pulse
  task automatic push_hold_out();
    for (int i = 0; i < 4; i++) begin
      push_tick(1'b1, SAMPLE_W'($urandom_range(1023)), 1'($urandom_range(1)));
    end
  endtask

  task automatic write_channels(input logic [adcma_pkg::MUX_BITS-1:0] f,
                                input logic [adcma_pkg::MUX_BITS-1:0] s);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= adcma_pkg::CFG_FIRST_CHANNEL;
    cfg_data  <= f;
    first_ch   = f;
    @(posedge clk);
    cfg_index <= adcma_pkg::CFG_SECOND_CHANNEL;
    cfg_data  <= s;
    second_ch  = s;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (tick_q.size() != 0 || in_valid || avg_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // driver: predict on accept, then offer the next tick word or idle
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predicted_word = advance_average(driven_tick);
        avg_q.push_back(predicted_word);
      end
      if (!in_valid || !in_stall) begin
        if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          driven_tick = tick_q.pop_front();
          in_valid         <= 1'b1;
          conversion_done  <= driven_tick.done;
          sample_value     <= driven_tick.sample;
          sampling_enabled <= driven_tick.enabled;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare accepted result words, stall at random
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (avg_q.size() == 0) begin
          $display("%0t: result word with none expected, actual start %0d mux %0d metal %0d color %0d",
                   $time, start_conversion, mux_select, metal_sum, color_sum);
          mismatch_count++;
        end else begin
          wanted_word = avg_q.pop_front();
          check_field("start_conversion", wanted_word.start, start_conversion);
          check_field("mux_select", wanted_word.mux, mux_select);
          check_field("metal_sum", wanted_word.metal, metal_sum);
          check_field("color_sum", wanted_word.color, color_sum);
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // watchdog on cycles with no handshake and no register write
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: timeout with %0d ticks pending and %0d result words expected",
               $time, tick_q.size(), avg_q.size());
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // phases of register settings and idling
  logic [adcma_pkg::MUX_BITS-1:0] first_set  [PHASES] =
    '{4'd0, 4'd15, 4'd9, 4'd0,  4'd15, 4'd5};
  logic [adcma_pkg::MUX_BITS-1:0] second_set [PHASES] =
    '{4'd1, 4'd0,  4'd9, 4'd15, 4'd15, 4'd10};

  initial begin
    foreach (metal_win[i]) metal_win[i] = '0;
    foreach (color_win[i]) color_win[i] = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    for (int p = 0; p < PHASES; p++) begin
      case (p / 2)
        0: begin send_idle_pct = 26; recv_idle_pct = 66; end
        1: begin send_idle_pct = 66; recv_idle_pct = 26; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      write_channels(first_set[p], second_set[p]);
      if (p == 0) begin
        // no done flag, then full-scale metal and zero color samples
        push_tick(1'b0, '1, 1'b1);
        push_tick(1'b1, '1, 1'b1);
        push_hold_out();
        push_tick(1'b0, '0, 1'b0);
        push_tick(1'b1, '0, 1'b1);
        push_hold_out();
        // disabled done tick still starts the hold
        push_tick(1'b1, 10'd512, 1'b0);
        push_hold_out();
        push_tick(1'b1, '1, 1'b1);
        push_hold_out();
      end
      for (int i = 0; i < TICKS_PER_PHASE; i++) begin
        tick_q.push_back(random_tick());
      end
      wait_drained();
    end
    if (avg_q.size() != 0) begin
      $display("%0t: %0d result words never arrived", $time, avg_q.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
